@@ hw/rtl/fpscr_pkg.sv @@
// Shared types, codes and decode helpers for the FPSCR status register unit.
package fpscr_pkg;

   localparam int WORD_W      = 32;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Action codes carried in the request beat.
   localparam logic [2:0] ACT_RAISE   = 3'd0;
   localparam logic [2:0] ACT_SET_FI  = 3'd1;
   localparam logic [2:0] ACT_MOVE_CR = 3'd2;
   localparam logic [2:0] ACT_READ    = 3'd3;
   localparam logic [2:0] ACT_WRITE   = 3'd4;

   // Exception codes.
   localparam logic [3:0] EXC_OX     = 4'd0;
   localparam logic [3:0] EXC_UX     = 4'd1;
   localparam logic [3:0] EXC_ZX     = 4'd2;
   localparam logic [3:0] EXC_VXSNAN = 4'd3;
   localparam logic [3:0] EXC_VXISI  = 4'd4;
   localparam logic [3:0] EXC_VXIDI  = 4'd5;
   localparam logic [3:0] EXC_VXZDZ  = 4'd6;
   localparam logic [3:0] EXC_VXIMZ  = 4'd7;
   localparam logic [3:0] EXC_VXVC   = 4'd8;
   localparam logic [3:0] EXC_VXSOFT = 4'd9;
   localparam logic [3:0] EXC_VXSQRT = 4'd10;
   localparam logic [3:0] EXC_VXCVI  = 4'd11;

   // Word bit positions (architectural bit b sits at word bit 31-b).
   localparam int BIT_FX  = 31;
   localparam int BIT_FEX = 30;
   localparam int BIT_VX  = 29;
   localparam int BIT_XX  = 25;
   localparam int BIT_FI  = 17;
   localparam int SUMMARY_LO = 25;
   localparam int ENABLE_LO  = 3;
   localparam int SUMMARY_W  = 5;
   localparam logic [WORD_W-1:0] INVALID_MASK = 32'h01F8_0700;

   typedef struct packed {
      logic [2:0] action;
      logic [3:0] exception_code;
      logic       fi_value;
      logic [2:0] field_index;
      logic [3:0] field_data;
   } req_payload_type;

   typedef struct packed {
      logic [3:0]        field_value;
      logic [WORD_W-1:0] fpscr_value;
      logic              enabled_exception;
      logic              fex_changed;
   } rsp_payload_type;

   // One classified update: new = (old & ~clr_mask) | set_mask.
   typedef struct packed {
      logic [WORD_W-1:0] set_mask;
      logic [WORD_W-1:0] clr_mask;
      logic              read_en;
      logic [2:0]        field_index;
   } op_type;

   // Word bit that an exception code raises; zero when the code is unknown.
   function automatic logic [WORD_W-1:0] exc_mask(input logic [3:0] code);
      logic [WORD_W-1:0] m;
      m = '0;
      case (code)
         EXC_OX:     m[28] = 1'b1;
         EXC_UX:     m[27] = 1'b1;
         EXC_ZX:     m[26] = 1'b1;
         EXC_VXSNAN: m[24] = 1'b1;
         EXC_VXISI:  m[23] = 1'b1;
         EXC_VXIDI:  m[22] = 1'b1;
         EXC_VXZDZ:  m[21] = 1'b1;
         EXC_VXIMZ:  m[20] = 1'b1;
         EXC_VXVC:   m[19] = 1'b1;
         EXC_VXSOFT: m[10] = 1'b1;
         EXC_VXSQRT: m[9]  = 1'b1;
         EXC_VXCVI:  m[8]  = 1'b1;
         default:    m = '0;
      endcase
      return m;
   endfunction

   // Exception bits of each nibble that a move to CR clears.
   function automatic logic [3:0] clear_bits(input logic [2:0] field);
      logic [3:0] c;
      case (field)
         3'd0:    c = 4'h9;
         3'd1:    c = 4'hf;
         3'd2:    c = 4'hf;
         3'd3:    c = 4'h8;
         3'd5:    c = 4'h7;
         default: c = 4'h0;
      endcase
      return c;
   endfunction

   // Word bit offset of a nibble; field 0 is the most significant.
   function automatic logic [4:0] nibble_lo(input logic [2:0] field);
      return {3'd7 - field, 2'b00};
   endfunction

endpackage

@@ hw/rtl/fpscr_exception_status_register_unit.sv @@
// Top level of the FPSCR exception status register unit.
//
// This unit holds a 32-bit PowerPC-style floating-point status and control
// register, cleared by reset, and applies one action per request beat:
// raise a sticky exception, set or clear FI, move a field to the condition
// register (returning it and clearing its exception bits), read a field, or
// write a field. After every action VX and FEX are recomputed, and each
// response beat carries the field read, the whole register, FEX and a flag
// telling whether FEX changed. The unit sustains one beat per cycle while
// responses are taken: a request is classified into set and clear masks as
// it is accepted and waits in a two-entry queue; whenever the response
// register is empty or being taken, the back end applies the head entry to
// the register and loads the response register. The single register update
// in the back end is what bounds the rate. Requests are accepted while the
// queue has room; a stalled response only backs up into the queue.
module fpscr_exception_status_register_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  fpscr_pkg::req_payload_type req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output fpscr_pkg::rsp_payload_type rsp_payload
);
   import fpscr_pkg::*;

   op_type front_op;
   op_type queue_op;
   logic   queue_full;
   logic   queue_valid;
   logic   queue_pop;

   // Classify the incoming beat.
   fpscr_front u_front (
      .req_payload (req_payload),
      .op          (front_op)
   );

   assign req_ready = !queue_full;

   // Decouples request acceptance from response back-pressure.
   fpscr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid && req_ready),
      .push_op   (front_op),
      .full      (queue_full),
      .not_empty (queue_valid),
      .pop       (queue_pop),
      .pop_op    (queue_op)
   );

   // Register update and response register.
   fpscr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .op_valid    (queue_valid),
      .op          (queue_op),
      .op_take     (queue_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ hw/rtl/fpscr_front.sv @@
// Front end: takes request beats and classifies them into set and clear masks.
module fpscr_front (
   input  fpscr_pkg::req_payload_type req_payload,
   output fpscr_pkg::op_type          op
);
   import fpscr_pkg::*;

   logic [WORD_W-1:0] nib_mask;
   logic [WORD_W-1:0] raise_mask;
   logic [4:0]        lo;

   always_comb begin
      lo         = nibble_lo(req_payload.field_index);
      nib_mask   = {{(WORD_W-4){1'b0}}, 4'hf} << lo;
      raise_mask = exc_mask(req_payload.exception_code);

      op.set_mask    = '0;
      op.clr_mask    = '0;
      op.read_en     = 1'b0;
      op.field_index = req_payload.field_index;

      case (req_payload.action)
         ACT_RAISE: begin
            if (raise_mask != '0) begin
               op.set_mask         = raise_mask;
               op.set_mask[BIT_FX] = 1'b1;
               // Invalid-operation classes also raise the VX summary.
               if (req_payload.exception_code >= EXC_VXSNAN) begin
                  op.set_mask[BIT_VX] = 1'b1;
               end
            end
         end
         ACT_SET_FI: begin
            if (req_payload.fi_value) begin
               op.set_mask[BIT_FI] = 1'b1;
               op.set_mask[BIT_XX] = 1'b1;
               op.set_mask[BIT_FX] = 1'b1;
            end else begin
               op.clr_mask[BIT_FI] = 1'b1;
            end
         end
         ACT_MOVE_CR: begin
            op.read_en  = 1'b1;
            op.clr_mask = {{(WORD_W-4){1'b0}}, clear_bits(req_payload.field_index)} << lo;
         end
         ACT_READ: begin
            op.read_en = 1'b1;
         end
         ACT_WRITE: begin
            op.clr_mask = nib_mask;
            op.set_mask = {{(WORD_W-4){1'b0}}, req_payload.field_data} << lo;
         end
         default: begin
            op.set_mask = '0;
         end
      endcase
   end

endmodule

@@ hw/rtl/fpscr_queue.sv @@
// Short first-in first-out queue of classified operations between front and back.
module fpscr_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  fpscr_pkg::op_type  push_op,
   output logic               full,
   output logic               not_empty,
   input  logic               pop,
   output fpscr_pkg::op_type  pop_op
);
   import fpscr_pkg::*;

   op_type              entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   localparam logic [QPTR_W-1:0] LAST_PTR = QPTR_W'(QUEUE_DEPTH - 1);
   localparam logic [QCNT_W-1:0] DEPTH_CNT = QCNT_W'(QUEUE_DEPTH);

   assign full      = (count_ff == DEPTH_CNT);
   assign not_empty = (count_ff != '0);
   assign pop_op    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

@@ hw/rtl/fpscr_back.sv @@
// Back end: applies operations to the status word and holds the response beat.
module fpscr_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       op_valid,
   input  fpscr_pkg::op_type          op,
   output logic                       op_take,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output fpscr_pkg::rsp_payload_type rsp_payload
);
   import fpscr_pkg::*;

   logic [WORD_W-1:0] status_ff, status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_payload_ff, rsp_payload_in;
   logic [WORD_W-1:0] w;
   logic [3:0]        prior_nibble;

   assign op_take     = op_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   always_comb begin
      prior_nibble = status_ff[nibble_lo(op.field_index) +: 4];
      w            = (status_ff & ~op.clr_mask) | op.set_mask;
      // The VX and FEX summary bits are recomputed after every update.
      w[BIT_VX]  = |(w & INVALID_MASK);
      w[BIT_FEX] = |(w[SUMMARY_LO +: SUMMARY_W] & w[ENABLE_LO +: SUMMARY_W]);

      status_in      = op_take ? w : status_ff;
      rsp_valid_in   = op_take || (rsp_valid_ff && !rsp_ready);
      rsp_payload_in = rsp_payload_ff;
      if (op_take) begin
         rsp_payload_in.field_value       = op.read_en ? prior_nibble : 4'h0;
         rsp_payload_in.fpscr_value       = w;
         rsp_payload_in.enabled_exception = w[BIT_FEX];
         rsp_payload_in.fex_changed       = w[BIT_FEX] ^ status_ff[BIT_FEX];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

endmodule

@@ dv/fpscr_exception_status_register_unit_test.sv @@
// Self-checking testbench for the FPSCR exception status register unit.
module fpscr_exception_status_register_unit_test;
   import fpscr_pkg::*;

   // Codes outside the defined ranges; the unit must treat them as no-ops.
   localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
   localparam logic [2:0] ACT_UNUSED_HI = 3'd7;
   localparam logic [3:0] EXC_UNUSED_LO = 4'd12;
   localparam logic [3:0] EXC_UNUSED_HI = 4'd15;

   localparam int RESET_CYCLES   = 4;
   localparam int BEATS_PER_LEG  = 510;
   localparam int HOLD_CYCLES    = 64;
   localparam int DRAIN_CYCLES   = 8;
   localparam int STALL_LIMIT    = 1000;
   localparam int REPORT_LIMIT   = 10;

   typedef struct {
      req_payload_type item;
      bit              pinned;
      rsp_payload_type result;
   } script_row_type;

   logic            clock = 1'b0;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_payload;

   // Shadow copy of the status register, advanced once per accepted request beat.
   logic [WORD_W-1:0] shadow_fpscr = '0;
   rsp_payload_type   pending_rsp_q[$];
   int                fault_count = 0;
   int                tx_idle_pct = 0;
   int                rx_idle_pct = 0;
   int                hold_requests = 0;

   fpscr_exception_status_register_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #10 clock = ~clock;

   // Applies one action to the shadow register and returns the response it causes.
   function automatic rsp_payload_type apply_action(input req_payload_type item);
      rsp_payload_type r;
      logic [WORD_W-1:0] w;
      logic [3:0] prior;
      logic [3:0] sticky;
      logic old_fex;
      int lo;
      int arch_bit;
      r = '0;
      w = shadow_fpscr;
      lo = (7 - int'(item.field_index)) * 4;
      prior = w[lo +: 4];
      old_fex = w[BIT_FEX];
      case (item.action)
         ACT_RAISE: begin
            arch_bit = -1;
            case (item.exception_code)
               EXC_OX:     arch_bit = 3;
               EXC_UX:     arch_bit = 4;
               EXC_ZX:     arch_bit = 5;
               EXC_VXSNAN: arch_bit = 7;
               EXC_VXISI:  arch_bit = 8;
               EXC_VXIDI:  arch_bit = 9;
               EXC_VXZDZ:  arch_bit = 10;
               EXC_VXIMZ:  arch_bit = 11;
               EXC_VXVC:   arch_bit = 12;
               EXC_VXSOFT: arch_bit = 21;
               EXC_VXSQRT: arch_bit = 22;
               EXC_VXCVI:  arch_bit = 23;
               default:    arch_bit = -1;
            endcase
            // An unknown code sets nothing, not even the summary bit.
            if (arch_bit >= 0) begin
               w[31 - arch_bit] = 1'b1;
               if (item.exception_code >= EXC_VXSNAN) w[BIT_VX] = 1'b1;
               w[BIT_FX] = 1'b1;
            end
         end
         ACT_SET_FI: begin
            if (item.fi_value) begin
               w[BIT_FI] = 1'b1;
               w[BIT_XX] = 1'b1;
               w[BIT_FX] = 1'b1;
            end else begin
               w[BIT_FI] = 1'b0;
            end
         end
         ACT_MOVE_CR: begin
            case (item.field_index)
               3'd0:    sticky = 4'h9;
               3'd1:    sticky = 4'hf;
               3'd2:    sticky = 4'hf;
               3'd3:    sticky = 4'h8;
               3'd5:    sticky = 4'h7;
               default: sticky = 4'h0;
            endcase
            r.field_value = prior;
            w[lo +: 4] = prior & ~sticky;
         end
         ACT_READ: r.field_value = prior;
         ACT_WRITE: w[lo +: 4] = item.field_data;
         default: ;
      endcase
      // VX first, since FEX looks at VX against VE.
      w[BIT_VX] = |(w & INVALID_MASK);
      w[BIT_FEX] = |(w[SUMMARY_LO +: SUMMARY_W] & w[ENABLE_LO +: SUMMARY_W]);
      shadow_fpscr = w;
      r.fpscr_value = w;
      r.enabled_exception = w[BIT_FEX];
      r.fex_changed = w[BIT_FEX] ^ old_fex;
      return r;
   endfunction

   function automatic script_row_type row(input logic [2:0] action,
                                          input logic [3:0] code,
                                          input logic       fi,
                                          input logic [2:0] field,
                                          input logic [3:0] data,
                                          input bit         pinned = 1'b0,
                                          input logic [31:0] word = '0);
      script_row_type s;
      s.item.action = action;
      s.item.exception_code = code;
      s.item.fi_value = fi;
      s.item.field_index = field;
      s.item.field_data = data;
      s.pinned = pinned;
      // Pinned rows here read back only zero fields and never move FEX.
      s.result = '0;
      s.result.fpscr_value = word;
      return s;
   endfunction

   function automatic req_payload_type random_item();
      req_payload_type it;
      int pick;
      pick = $urandom_range(99);
      if (pick < 30) it.action = ACT_RAISE;
      else if (pick < 40) it.action = ACT_SET_FI;
      else if (pick < 55) it.action = ACT_MOVE_CR;
      else if (pick < 65) it.action = ACT_READ;
      else if (pick < 94) it.action = ACT_WRITE;
      else it.action = 3'($urandom_range(ACT_UNUSED_HI, ACT_UNUSED_LO));
      if ($urandom_range(99) < 90) it.exception_code = 4'($urandom_range(EXC_VXCVI, EXC_OX));
      else it.exception_code = 4'($urandom_range(EXC_UNUSED_HI, EXC_UNUSED_LO));
      it.fi_value = 1'($urandom_range(1));
      it.field_index = 3'($urandom_range(7));
      it.field_data = 4'($urandom_range(15));
      return it;
   endfunction

   task automatic log_fault(input string what);
      fault_count++;
      if (fault_count <= REPORT_LIMIT) $display("%0t: %s", $time, what);
   endtask

   // Offers one request beat, idling first at the current rate, and records
   // the expected response once the beat is taken.
   task automatic send_beat(input req_payload_type item, input bit pinned,
                            input rsp_payload_type result);
      rsp_payload_type predicted;
      @(negedge clock);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      predicted = apply_action(item);
      pending_rsp_q.push_back(pinned ? result : predicted);
   endtask

   // Response side: random back-pressure, plus a long hold-off on request so
   // that the request queue fills and req_ready drops.
   initial begin
      int hold_seen;
      int hold_left;
      hold_seen = 0;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // Response checker.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp_q.size() == 0) begin
            log_fault($sformatf("response beat with nothing pending: %p", rsp_payload));
         end else begin
            want = pending_rsp_q.pop_front();
            if (rsp_payload.field_value !== want.field_value)
               log_fault($sformatf("field_value expected %h got %h",
                                   want.field_value, rsp_payload.field_value));
            if (rsp_payload.fpscr_value !== want.fpscr_value)
               log_fault($sformatf("fpscr_value expected %h got %h",
                                   want.fpscr_value, rsp_payload.fpscr_value));
            if (rsp_payload.enabled_exception !== want.enabled_exception)
               log_fault($sformatf("enabled_exception expected %b got %b",
                                   want.enabled_exception, rsp_payload.enabled_exception));
            if (rsp_payload.fex_changed !== want.fex_changed)
               log_fault($sformatf("fex_changed expected %b got %b",
                                   want.fex_changed, rsp_payload.fex_changed));
         end
      end
   end

   // Watchdog: ends the run when no beat moves on either side for too long.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("fpscr_exception_status_register_unit verification failed");
      $finish;
   end

   initial begin
      script_row_type script[$];
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      tx_idle_pct = 37;
      rx_idle_pct = 78;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed opening, starting from the cleared register.
      script.push_back(row(ACT_READ, EXC_OX, 1'b0, 3'd0, 4'h0, 1'b1, 32'h0000_0000));
      script.push_back(row(ACT_RAISE, EXC_UNUSED_HI, 1'b0, 3'd0, 4'h0, 1'b1, 32'h0000_0000));
      script.push_back(row(ACT_RAISE, EXC_UNUSED_LO, 1'b1, 3'd7, 4'hf, 1'b1, 32'h0000_0000));
      script.push_back(row(ACT_UNUSED_HI, EXC_OX, 1'b1, 3'd7, 4'hf, 1'b1, 32'h0000_0000));
      script.push_back(row(ACT_UNUSED_LO, EXC_VXCVI, 1'b1, 3'd0, 4'hf));
      script.push_back(row(ACT_RAISE, EXC_OX, 1'b0, 3'd0, 4'h0, 1'b1, 32'h9000_0000));
      // Turning the enables on makes FEX rise from the pending overflow.
      script.push_back(row(ACT_WRITE, EXC_OX, 1'b0, 3'd6, 4'hf));
      script.push_back(row(ACT_WRITE, EXC_OX, 1'b0, 3'd7, 4'hf));
      script.push_back(row(ACT_RAISE, EXC_UX, 1'b0, 3'd0, 4'h0));
      script.push_back(row(ACT_RAISE, EXC_ZX, 1'b0, 3'd0, 4'h0));
      script.push_back(row(ACT_RAISE, EXC_VXSNAN, 1'b0, 3'd0, 4'h0));
      script.push_back(row(ACT_RAISE, EXC_VXVC, 1'b0, 3'd0, 4'h0));
      script.push_back(row(ACT_RAISE, EXC_VXCVI, 1'b0, 3'd0, 4'h0));
      script.push_back(row(ACT_SET_FI, EXC_OX, 1'b1, 3'd0, 4'h0));
      script.push_back(row(ACT_SET_FI, EXC_OX, 1'b0, 3'd0, 4'h0));
      // Moving fields to CR clears their sticky bits; VX and FEX follow.
      script.push_back(row(ACT_MOVE_CR, EXC_OX, 1'b0, 3'd0, 4'h0));
      script.push_back(row(ACT_MOVE_CR, EXC_OX, 1'b0, 3'd1, 4'h0));
      script.push_back(row(ACT_MOVE_CR, EXC_OX, 1'b0, 3'd2, 4'h0));
      script.push_back(row(ACT_MOVE_CR, EXC_OX, 1'b0, 3'd3, 4'h0));
      script.push_back(row(ACT_MOVE_CR, EXC_OX, 1'b0, 3'd5, 4'h0));
      script.push_back(row(ACT_MOVE_CR, EXC_OX, 1'b0, 3'd4, 4'h0));
      script.push_back(row(ACT_READ, EXC_OX, 1'b0, 3'd7, 4'h0));
      // Written FEX and VX values do not survive the recompute.
      script.push_back(row(ACT_WRITE, EXC_OX, 1'b0, 3'd0, 4'hf));
      script.push_back(row(ACT_WRITE, EXC_OX, 1'b0, 3'd0, 4'h0));
      script.push_back(row(ACT_MOVE_CR, EXC_OX, 1'b0, 3'd7, 4'h0));
      foreach (script[i]) send_beat(script[i].item, script[i].pinned, script[i].result);

      // Random legs: sender mostly busy, then receiver mostly busy, then no
      // idling at all with one long response hold-off.
      for (int leg = 0; leg < 3; leg++) begin
         case (leg)
            0: begin
               tx_idle_pct = 37;
               rx_idle_pct = 78;
            end
            1: begin
               tx_idle_pct = 78;
               rx_idle_pct = 37;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
               hold_requests++;
            end
         endcase
         repeat (BEATS_PER_LEG) send_beat(random_item(), 1'b0, '0);
      end
      @(negedge clock);
      req_valid <= 1'b0;

      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("fpscr_exception_status_register_unit verification clean");
      end else begin
         $display("fpscr_exception_status_register_unit verification failed");
      end
      $finish;
   end

endmodule
